// ----- rtl/c8x_pkg.sv -----
package c8x_pkg;

   localparam int MEM_AW = 12;

   typedef enum logic [2:0] {
      CMD_EXEC  = 3'd0,
      CMD_TICK  = 3'd1,
      CMD_KEY   = 3'd2,
      CMD_WRMEM = 3'd3,
      CMD_RDMEM = 3'd4,
      CMD_RDFB  = 3'd5,
      CMD_NOP6  = 3'd6,
      CMD_NOP7  = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNKNOWN = 2'd1,
      ST_WAITKEY = 2'd2,
      ST_RSVD    = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CLEARM, S_FETCH_HI, S_FETCH_LO, S_DECODE, S_EXEC,
      S_RDMEM, S_RDFB, S_CLS, S_DRAW_RD, S_DRAW_LINE, S_DRAW_FB0, S_DRAW_FB1,
      S_DRAW_WR, S_BCD, S_STORE, S_LOAD_RD, S_LOAD_WR, S_RET_RD, S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] program_counter;
      logic [15:0] executed_opcode;
      logic [7:0]  read_byte;
      logic [7:0]  flag_register;
      logic        sound_on;
   } rsp_type;

   function automatic logic [7:0] font_byte(input logic [6:0] a);
      logic [7:0] v;
      unique case (a)
         7'd0: v = 8'hF0; 7'd1: v = 8'h90; 7'd2: v = 8'h90; 7'd3: v = 8'h90;
         7'd4: v = 8'hF0; 7'd5: v = 8'h20; 7'd6: v = 8'h60; 7'd7: v = 8'h20;
         7'd8: v = 8'h20; 7'd9: v = 8'h70; 7'd10: v = 8'hF0; 7'd11: v = 8'h10;
         7'd12: v = 8'hF0; 7'd13: v = 8'h80; 7'd14: v = 8'hF0; 7'd15: v = 8'hF0;
         7'd16: v = 8'h10; 7'd17: v = 8'hF0; 7'd18: v = 8'h10; 7'd19: v = 8'hF0;
         7'd20: v = 8'h90; 7'd21: v = 8'h90; 7'd22: v = 8'hF0; 7'd23: v = 8'h10;
         7'd24: v = 8'h10; 7'd25: v = 8'hF0; 7'd26: v = 8'h80; 7'd27: v = 8'hF0;
         7'd28: v = 8'h10; 7'd29: v = 8'hF0; 7'd30: v = 8'hF0; 7'd31: v = 8'h80;
         7'd32: v = 8'hF0; 7'd33: v = 8'h90; 7'd34: v = 8'hF0; 7'd35: v = 8'hF0;
         7'd36: v = 8'h10; 7'd37: v = 8'h20; 7'd38: v = 8'h40; 7'd39: v = 8'h40;
         7'd40: v = 8'hF0; 7'd41: v = 8'h90; 7'd42: v = 8'hF0; 7'd43: v = 8'h90;
         7'd44: v = 8'hF0; 7'd45: v = 8'hF0; 7'd46: v = 8'h90; 7'd47: v = 8'hF0;
         7'd48: v = 8'h10; 7'd49: v = 8'hF0; 7'd50: v = 8'hF0; 7'd51: v = 8'h90;
         7'd52: v = 8'hF0; 7'd53: v = 8'h90; 7'd54: v = 8'h90; 7'd55: v = 8'hE0;
         7'd56: v = 8'h90; 7'd57: v = 8'hE0; 7'd58: v = 8'h90; 7'd59: v = 8'hE0;
         7'd60: v = 8'hF0; 7'd61: v = 8'h80; 7'd62: v = 8'h80; 7'd63: v = 8'h80;
         7'd64: v = 8'hF0; 7'd65: v = 8'hE0; 7'd66: v = 8'h90; 7'd67: v = 8'h90;
         7'd68: v = 8'h90; 7'd69: v = 8'hE0; 7'd70: v = 8'hF0; 7'd71: v = 8'h80;
         7'd72: v = 8'hF0; 7'd73: v = 8'h80; 7'd74: v = 8'hF0; 7'd75: v = 8'hF0;
         7'd76: v = 8'h80; 7'd77: v = 8'hF0; 7'd78: v = 8'h80; 7'd79: v = 8'h80;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/c8x_ram.sv -----
module c8x_ram #(
   parameter int AW = 12,
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);
   logic [DW-1:0] mem [(1<<AW)];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

// ----- rtl/chip8_instruction_executor.sv -----
// channel | dir | payload
// req_*   | in  | tdata: cmd[2:0], address[14:3], write_value[22:15]
// rsp_*   | out | tdata: status, program_counter, executed_opcode, read_byte, flag, sound
// csr_*   | in  | random_seed, 16 bits
// a draw steps through every sprite row and bit, reading and rewriting a display
// byte only for a set bit; FX55 and FX65 move one register at a time, and
// clear screen writes the display bytes in turn.
// after reset a clearing pass over all 4096 bytes loads font and zeros main memory,
// then the display is zeroed byte by byte.
// one item at a time; a result waits in the output register until taken.
module chip8_instruction_executor #(
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // cmd, address, write_value, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // status, program_counter, executed_opcode,
                                   // read_byte, flag_register, sound_on, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import c8x_pkg::*;

   localparam int ROWB    = SCREEN_WIDTH / 8;
   localparam int FB_SIZE = ROWB * SCREEN_HEIGHT;
   localparam int FBAW    = $clog2(FB_SIZE);
   localparam int CW      = $clog2(SCREEN_WIDTH);
   localparam int RW      = $clog2(SCREEN_HEIGHT);
   localparam int BW      = CW - 3;

   state_type   state_ff, state_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [11:0] addr_ff, addr_in;
   logic [15:0] op_ff, op_in;
   logic [11:0] pc_ff, pc_in, ireg_ff, ireg_in;
   logic [3:0]  sp_ff, sp_in;
   logic [7:0]  dt_ff, dt_in, st_ff, st_in, key_ff, key_in;
   logic [15:0] lfsr_ff, lfsr_in;
   logic [7:0]  v_ff [16];
   logic [7:0]  v_in [16];
   logic [11:0] cnt_ff, cnt_in;
   logic [3:0]  row_ff, row_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  line_ff, line_in;
   logic        hit_ff, hit_in;
   logic [7:0]  fbb_ff, fbb_in;
   logic [1:0]  stat_ff, stat_in;
   logic [7:0]  rd_ff, rd_in;
   logic        rv_ff, rv_in;
   rsp_type     rsp_ff, rsp_in;

   logic        mwe, fwe, kwe;
   logic [11:0] maddr, kwd, krd;
   logic [7:0]  mwd, mrd, fwd, frd;
   logic [FBAW-1:0] faddr;
   logic [3:0]  kaddr;

   c8x_ram #(.AW(12), .DW(8)) u_mem (.clock, .we(mwe), .addr(maddr), .wdata(mwd),
      .rdata(mrd));
   c8x_ram #(.AW(FBAW), .DW(8)) u_fb (.clock, .we(fwe), .addr(faddr), .wdata(fwd),
      .rdata(frd));
   c8x_ram #(.AW(4), .DW(12)) u_stk (.clock, .we(kwe), .addr(kaddr), .wdata(kwd),
      .rdata(krd));

   logic [3:0]  ox, oy, on;
   logic [7:0]  vx, vy, kk;
   logic [11:0] pc2, pc4;
   logic [8:0]  sum9;
   logic [CW-1:0] col;
   logic [RW-1:0] rowp;
   logic [FBAW-1:0] fbidx;
   logic [7:0]  bmask;
   logic        fb0;
   logic [7:0]  q10, q100;
   logic [15:0] lnext;
   logic [8:0]  rsum;
   logic [7:0]  rmod;
   logic [7:0]  rnd;

   always_comb begin
      ox  = op_ff[11:8];
      oy  = op_ff[7:4];
      on  = op_ff[3:0];
      kk  = op_ff[7:0];
      vx  = v_ff[ox];
      vy  = v_ff[oy];
      pc2 = pc_ff + 12'd2;
      pc4 = pc_ff + 12'd4;
      sum9 = {1'b0, vx} + {1'b0, vy};
      col  = CW'(vx + {5'd0, bit_ff});
      rowp = RW'(vy + {4'd0, row_ff});
      fbidx = FBAW'(rowp * ROWB) + FBAW'(col >> 3);
      bmask = 8'd1 << col[2:0];
      fb0 = lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5];
      lnext = {fb0, lfsr_ff[15:1]};
      // 256 is 1 mod 255, so the byte sum folds the value
      rsum = {1'b0, lnext[15:8]} + {1'b0, lnext[7:0]};
      rmod = (rsum >= 9'd255) ? 8'(rsum - 9'd255) : rsum[7:0];
      rnd  = (rmod == 8'hFF) ? 8'd0 : rmod;
      q100 = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
      q10  = 8'((16'(vx) * 16'd205) >> 11);
   end

   // next state and register updates
   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff; addr_in = addr_ff; op_in = op_ff;
      pc_in = pc_ff; ireg_in = ireg_ff; sp_in = sp_ff; dt_in = dt_ff; st_in = st_ff;
      key_in = key_ff; lfsr_in = lfsr_ff; v_in = v_ff;
      cnt_in = cnt_ff; row_in = row_ff; bit_in = bit_ff; line_in = line_ff;
      hit_in = hit_ff; fbb_in = fbb_ff; stat_in = stat_ff; rd_in = rd_ff;
      rv_in = rv_ff; rsp_in = rsp_ff;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      if (csr_valid) lfsr_in = csr_data;
      unique case (state_ff)
         S_CLEARM: begin
            cnt_in = cnt_ff + 12'd1;
            if (cnt_ff == 12'hFFF) state_in = S_CLS;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tdata[2:0]; addr_in = req_tdata[14:3];
               op_in = '0; stat_in = ST_OK; rd_in = '0;
               unique case (cmd_type'(req_tdata[2:0]))
                  CMD_EXEC:  state_in = S_FETCH_HI;
                  CMD_TICK: begin
                     if (dt_ff != 0) dt_in = dt_ff - 8'd1;
                     if (st_ff != 0) st_in = st_ff - 8'd1;
                     state_in = S_RESP;
                  end
                  CMD_KEY: begin key_in = req_tdata[22:15]; state_in = S_RESP; end
                  CMD_WRMEM: state_in = S_RESP;
                  CMD_RDMEM: state_in = S_RDMEM;
                  CMD_RDFB:  state_in = S_RDFB;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_RDMEM: begin rd_in = mrd; state_in = S_RESP; end
         S_RDFB: begin
            rd_in = (addr_ff < 12'(FB_SIZE)) ? frd : 8'd0; state_in = S_RESP;
         end
         S_FETCH_HI: state_in = S_FETCH_LO;
         S_FETCH_LO: begin op_in[15:8] = mrd; state_in = S_DECODE; end
         S_DECODE: begin op_in[7:0] = mrd; state_in = S_EXEC; end
         S_EXEC: begin
            pc_in = pc2;
            state_in = S_RESP;
            unique case (op_ff[15:12])
               4'h0: begin
                  if (op_ff == 16'h00E0) begin cnt_in = '0; state_in = S_CLS; end
                  else if (op_ff == 16'h00EE) state_in = S_RET_RD;
               end
               4'h1: pc_in = op_ff[11:0];
               4'h2: begin sp_in = sp_ff + 4'd1; pc_in = op_ff[11:0]; end
               4'h3: if (vx == kk) pc_in = pc4;
               4'h4: if (vx != kk) pc_in = pc4;
               4'h5: if (vx == vy) pc_in = pc4;
               4'h6: v_in[ox] = kk;
               4'h7: v_in[ox] = vx + kk;
               4'h8: begin
                  unique case (on)
                     4'h0: v_in[ox] = vy;
                     4'h1: v_in[ox] = vx | vy;
                     4'h2: v_in[ox] = vx & vy;
                     4'h3: v_in[ox] = vx ^ vy;
                     4'h4: begin v_in[ox] = sum9[7:0]; v_in[15] = {7'd0, sum9[8]}; end
                     4'h5: begin v_in[ox] = vx - vy; v_in[15] = {7'd0, vx >= vy}; end
                     4'h6: begin v_in[ox] = vx >> 1; v_in[15] = {7'd0, vx[0]}; end
                     4'h7: begin v_in[ox] = vy - vx; v_in[15] = {7'd0, vy >= vx}; end
                     4'hE: begin v_in[ox] = vx << 1; v_in[15] = {7'd0, vx[7]}; end
                     default: stat_in = ST_UNKNOWN;
                  endcase
               end
               4'h9: if (vx != vy) pc_in = pc4;
               4'hA: ireg_in = op_ff[11:0];
               4'hB: pc_in = op_ff[11:0] + {4'd0, v_ff[0]};
               4'hC: begin lfsr_in = lnext; v_in[ox] = rnd & kk; end
               4'hD: begin
                  hit_in = 1'b0; row_in = '0; bit_in = '0;
                  if (on == 0) v_in[15] = 8'd0;
                  else state_in = S_DRAW_RD;
               end
               4'hE: begin
                  if (kk == 8'h9E) begin
                     if (key_ff != 0 && vx == key_ff) pc_in = pc4;
                  end else if (kk == 8'hA1) begin
                     if (!(key_ff != 0 && vx == key_ff)) pc_in = pc4;
                  end else stat_in = ST_UNKNOWN;
               end
               default: begin
                  unique case (kk)
                     8'h07: v_in[ox] = dt_ff;
                     8'h0A: if (key_ff == 0) begin pc_in = pc_ff; stat_in = ST_WAITKEY; end
                            else v_in[ox] = key_ff;
                     8'h15: dt_in = vx;
                     8'h18: st_in = vx;
                     8'h1E: ireg_in = ireg_ff + {4'd0, vx};
                     8'h29: ireg_in = {2'b00, vx, 2'b00} + {4'd0, vx};
                     8'h33: begin cnt_in = '0; state_in = S_BCD; end
                     8'h55: begin cnt_in = '0; state_in = S_STORE; end
                     8'h65: begin cnt_in = '0; state_in = S_LOAD_RD; end
                     default: stat_in = ST_UNKNOWN;
                  endcase
               end
            endcase
         end
         S_RET_RD: begin pc_in = krd; sp_in = sp_ff - 4'd1; state_in = S_RESP; end
         S_CLS: begin
            cnt_in = cnt_ff + 12'd1;
            if (cnt_ff == 12'(FB_SIZE - 1)) begin
               cnt_in = '0;
               state_in = (cmd_ff == CMD_EXEC) ? S_RESP : S_IDLE;
            end
         end
         S_BCD: begin
            cnt_in = cnt_ff + 12'd1;
            if (cnt_ff == 12'd2) state_in = S_RESP;
         end
         S_STORE: begin
            cnt_in = cnt_ff + 12'd1;
            if (cnt_ff[3:0] == ox) state_in = S_RESP;
         end
         S_LOAD_RD: state_in = S_LOAD_WR;
         S_LOAD_WR: begin
            v_in[cnt_ff[3:0]] = mrd;
            cnt_in = cnt_ff + 12'd1;
            state_in = (cnt_ff[3:0] == ox) ? S_RESP : S_LOAD_RD;
         end
         S_DRAW_RD: state_in = S_DRAW_LINE;
         S_DRAW_LINE: begin line_in = mrd; bit_in = '0; state_in = S_DRAW_FB0; end
         S_DRAW_FB0: begin
            if (line_ff[3'd7 - bit_ff]) state_in = S_DRAW_FB1;
            else if (bit_ff == 3'd7) begin
               row_in = row_ff + 4'd1;
               if (row_ff + 4'd1 == on) begin v_in[15] = {7'd0, hit_ff}; state_in = S_RESP; end
               else state_in = S_DRAW_RD;
            end else bit_in = bit_ff + 3'd1;
         end
         S_DRAW_FB1: begin fbb_in = frd; state_in = S_DRAW_WR; end
         S_DRAW_WR: begin
            if ((fbb_ff & bmask) != 0) hit_in = 1'b1;
            if (bit_ff == 3'd7) begin
               row_in = row_ff + 4'd1;
               if (row_ff + 4'd1 == on) begin
                  v_in[15] = {7'd0, hit_ff | ((fbb_ff & bmask) != 0)};
                  state_in = S_RESP;
               end else state_in = S_DRAW_RD;
            end else begin bit_in = bit_ff + 3'd1; state_in = S_DRAW_FB0; end
         end
         S_RESP: begin
            if (!rv_ff || rsp_tready) begin
               rsp_in.status = stat_in;
               rsp_in.program_counter = pc_ff;
               rsp_in.executed_opcode = op_ff;
               rsp_in.read_byte = rd_ff;
               rsp_in.flag_register = v_ff[15];
               rsp_in.sound_on = st_ff != 0;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory port drive
   always_comb begin
      mwe = 1'b0; maddr = pc_ff; mwd = '0;
      fwe = 1'b0; faddr = addr_ff[FBAW-1:0]; fwd = '0;
      kwe = 1'b0; kaddr = sp_ff; kwd = pc2;
      unique case (state_ff)
         S_CLEARM: begin
            mwe = 1'b1; maddr = cnt_ff;
            mwd = (cnt_ff < 12'd80) ? font_byte(cnt_ff[6:0]) : 8'd0;
         end
         S_IDLE: begin
            maddr = req_tdata[14:3];
            faddr = req_tdata[3+FBAW-1:3];
            mwe = req_tvalid && (req_tdata[2:0] == CMD_WRMEM);
            mwd = req_tdata[22:15];
         end
         S_FETCH_HI: maddr = pc_ff;
         S_FETCH_LO: maddr = pc_ff + 12'd1;
         S_EXEC: if (op_ff[15:12] == 4'h2) begin kwe = 1'b1; kaddr = sp_ff + 4'd1; end
         S_CLS: begin fwe = 1'b1; faddr = cnt_ff[FBAW-1:0]; end
         S_BCD: begin
            mwe = 1'b1; maddr = ireg_ff + cnt_ff;
            unique case (cnt_ff[1:0])
               2'd0: mwd = q100;
               2'd1: mwd = q10 - ((q10 >= 8'd10) ? 8'd10 : 8'd0) -
                           ((q10 >= 8'd20) ? 8'd10 : 8'd0);
               default: mwd = vx - 8'(q10 * 8'd10);
            endcase
         end
         S_STORE: begin mwe = 1'b1; maddr = ireg_ff + cnt_ff; mwd = v_ff[cnt_ff[3:0]]; end
         S_LOAD_RD: maddr = ireg_ff + cnt_ff;
         S_DRAW_RD: maddr = ireg_ff + {8'd0, row_ff};
         S_DRAW_FB0: faddr = fbidx;
         S_DRAW_WR: begin fwe = 1'b1; faddr = fbidx; fwd = fbb_ff ^ bmask; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEARM;
         cnt_ff <= '0; cmd_ff <= CMD_TICK;
         pc_ff <= 12'h200; ireg_ff <= '0; sp_ff <= '0; dt_ff <= '0; st_ff <= '0;
         key_ff <= '0; lfsr_ff <= 16'hACE1; rv_ff <= 1'b0;
         for (int i = 0; i < 16; i++) v_ff[i] <= '0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; cmd_ff <= cmd_in;
         pc_ff <= pc_in; ireg_ff <= ireg_in; sp_ff <= sp_in; dt_ff <= dt_in;
         st_ff <= st_in; key_ff <= key_in; lfsr_ff <= lfsr_in; rv_ff <= rv_in;
         v_ff <= v_in;
      end
      addr_ff <= addr_in; op_ff <= op_in; row_ff <= row_in;
      bit_ff <= bit_in; line_ff <= line_in; hit_ff <= hit_in; fbb_ff <= fbb_in;
      stat_ff <= stat_in; rd_ff <= rd_in; rsp_ff <= rsp_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.sound_on, rsp_ff.flag_register, rsp_ff.read_byte,
                        rsp_ff.executed_opcode, rsp_ff.program_counter, rsp_ff.status};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transfer accepted while busy");
   a_sp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RET_RD |=> sp_ff == $past(sp_ff) - 4'd1)
      else $error("stack pointer not popped");
endmodule

// ----- tb/sv/tb_chip8_instruction_executor.sv -----
`timescale 1ns / 1ps

module tb_chip8_instruction_executor;
   import c8x_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int FB_SIZE     = 256;

   typedef struct {
      status_type  status;
      logic [11:0] pc;
      logic [15:0] opword;
      logic [7:0]  rd;
      logic [7:0]  vf;
      logic        snd;
   } outcome_type;

   typedef enum logic { ROW_CMD, ROW_OPCODE } row_kind_type;

   typedef struct {
      row_kind_type kind;
      cmd_type      cmd;
      logic [11:0]  addr;
      logic [15:0]  value;   // write value, or opcode for program rows
      bit           hand;
      outcome_type  want;
   } stim_row_type;

   localparam logic [7:0] GLYPHS [80] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   // shadow of the core state
   logic [7:0]  mem_img [4096];
   logic [7:0]  fb_img [FB_SIZE];
   logic [7:0]  vreg [16];
   logic [11:0] ret_stack [16];
   bit          ret_valid [16];
   logic [11:0] pc_q;
   logic [11:0] idx_q;
   logic [3:0]  sp_q;
   logic [7:0]  delay_q;
   logic [7:0]  sound_q;
   logic [7:0]  key_q;
   logic [15:0] lfsr_q;

   outcome_type pending_rsp [$];
   int          mismatches;
   int          checked;
   int          executed;
   int          draws;
   int          cycles;
   bit          quiet;
   int          stall_left;

   chip8_instruction_executor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] lfsr_byte();
      logic fb;
      fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
      lfsr_q = {fb, lfsr_q[15:1]};
      return 8'(lfsr_q % 16'd255);
   endfunction

   function automatic void sprite_xor(logic [7:0] vx, logic [7:0] vy, int rows);
      logic [7:0] line;
      int col, row, pos;
      logic hit;
      hit = 1'b0;
      for (int r = 0; r < rows; r++) begin
         line = mem_img[12'(idx_q + r)];
         for (int b = 0; b < 8; b++) begin
            if (line[7 - b]) begin
               col = (vx + b) % 64;
               row = (vy + r) % 32;
               pos = row * 8 + col / 8;
               if (fb_img[pos][col % 8]) hit = 1'b1;
               fb_img[pos][col % 8] = ~fb_img[pos][col % 8];
            end
         end
      end
      vreg[15] = {7'd0, hit};
   endfunction

   function automatic status_type run_opcode(logic [15:0] op);
      logic [3:0]  x, y, n;
      logic [7:0]  kk, vx, vy;
      logic [11:0] nnn, nxt;
      logic        down;
      status_type  st;
      x = op[11:8]; y = op[7:4]; n = op[3:0];
      kk = op[7:0]; nnn = op[11:0];
      vx = vreg[x]; vy = vreg[y];
      nxt = pc_q + 12'd2;
      st = ST_OK;
      case (op[15:12])
         4'h0: begin
            if (op == 16'h00E0) begin
               foreach (fb_img[i]) fb_img[i] = 8'd0;
            end else if (op == 16'h00EE) begin
               nxt = ret_stack[sp_q];
               sp_q = sp_q - 4'd1;
            end
         end
         4'h1: nxt = nnn;
         4'h2: begin
            sp_q = sp_q + 4'd1;
            ret_stack[sp_q] = nxt;
            ret_valid[sp_q] = 1'b1;
            nxt = nnn;
         end
         4'h3: if (vx == kk) nxt = nxt + 12'd2;
         4'h4: if (vx != kk) nxt = nxt + 12'd2;
         4'h5: if (vx == vy) nxt = nxt + 12'd2;
         4'h6: vreg[x] = kk;
         4'h7: vreg[x] = vx + kk;
         4'h8: begin
            case (n)
               4'h0: vreg[x] = vy;
               4'h1: vreg[x] = vx | vy;
               4'h2: vreg[x] = vx & vy;
               4'h3: vreg[x] = vx ^ vy;
               4'h4: begin vreg[x] = vx + vy; vreg[15] = 8'({1'b0, vx} + vy > 9'hFF); end
               4'h5: begin vreg[x] = vx - vy; vreg[15] = 8'(vx >= vy); end
               4'h6: begin vreg[x] = vx >> 1; vreg[15] = 8'(vx[0]); end
               4'h7: begin vreg[x] = vy - vx; vreg[15] = 8'(vy >= vx); end
               4'hE: begin vreg[x] = vx << 1; vreg[15] = 8'(vx[7]); end
               default: st = ST_UNKNOWN;
            endcase
         end
         4'h9: if (vx != vy) nxt = nxt + 12'd2;
         4'hA: idx_q = nnn;
         4'hB: nxt = nnn + 12'(vreg[0]);
         4'hC: vreg[x] = lfsr_byte() & kk;
         4'hD: sprite_xor(vx, vy, n);
         4'hE: begin
            down = (key_q != 8'd0) && (vx == key_q);
            if (kk == 8'h9E) begin
               if (down) nxt = nxt + 12'd2;
            end else if (kk == 8'hA1) begin
               if (!down) nxt = nxt + 12'd2;
            end else st = ST_UNKNOWN;
         end
         default: begin
            case (kk)
               8'h07: vreg[x] = delay_q;
               8'h0A: begin
                  if (key_q == 8'd0) begin
                     nxt = pc_q;
                     st = ST_WAITKEY;
                  end else vreg[x] = key_q;
               end
               8'h15: delay_q = vx;
               8'h18: sound_q = vx;
               8'h1E: idx_q = idx_q + 12'(vx);
               8'h29: idx_q = 12'(vx * 5);
               8'h33: begin
                  mem_img[idx_q] = vx / 100;
                  mem_img[12'(idx_q + 1)] = (vx / 10) % 10;
                  mem_img[12'(idx_q + 2)] = vx % 10;
               end
               8'h55: for (int i = 0; i <= x; i++) mem_img[12'(idx_q + i)] = vreg[i];
               8'h65: for (int i = 0; i <= x; i++) vreg[i] = mem_img[12'(idx_q + i)];
               default: st = ST_UNKNOWN;
            endcase
         end
      endcase
      pc_q = nxt;
      return st;
   endfunction

   function automatic outcome_type predict_core(cmd_type cmd, logic [11:0] addr,
                                                logic [7:0] val);
      outcome_type o;
      o.status = ST_OK;
      o.opword = 16'd0;
      o.rd = 8'd0;
      case (cmd)
         CMD_EXEC: begin
            o.opword = {mem_img[pc_q], mem_img[12'(pc_q + 1)]};
            if (o.opword[15:12] == 4'hD) draws++;
            executed++;
            o.status = run_opcode(o.opword);
         end
         CMD_TICK: begin
            if (delay_q != 8'd0) delay_q--;
            if (sound_q != 8'd0) sound_q--;
         end
         CMD_KEY:   key_q = val;
         CMD_WRMEM: mem_img[addr] = val;
         CMD_RDMEM: o.rd = mem_img[addr];
         CMD_RDFB:  o.rd = (addr < FB_SIZE) ? fb_img[addr] : 8'd0;
         default: ;
      endcase
      o.pc = pc_q;
      o.vf = vreg[15];
      o.snd = (sound_q != 8'd0);
      return o;
   endfunction

   task automatic send_cmd(cmd_type cmd, logic [11:0] addr, logic [7:0] val,
                           bit hand = 1'b0,
                           outcome_type want = '{status: ST_OK, default: '0});
      outcome_type o;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, val, addr, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      o = predict_core(cmd, addr, val);
      pending_rsp.push_back(hand ? want : o);
   endtask

   // places an opcode at the program counter and runs it
   task automatic run_program_step(logic [15:0] op);
      if (op == 16'h00EE && !ret_valid[sp_q]) op = 16'h00E0;
      send_cmd(CMD_WRMEM, pc_q, op[15:8]);
      send_cmd(CMD_WRMEM, pc_q + 12'd1, op[7:0]);
      send_cmd(CMD_EXEC, 12'd0, 8'd0);
   endtask

   // runs whatever the memory holds, turning a return through an empty slot into a clear screen
   task automatic run_in_place();
      if ({mem_img[pc_q], mem_img[12'(pc_q + 1)]} == 16'h00EE && !ret_valid[sp_q])
         send_cmd(CMD_WRMEM, pc_q + 12'd1, 8'hE0);
      send_cmd(CMD_EXEC, 12'd0, 8'd0);
   endtask

   task automatic load_seed(logic [15:0] seed);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= seed;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      lfsr_q = seed;
   endtask

   function automatic logic [15:0] pick_opcode();
      logic [3:0]  x, y, n;
      logic [7:0]  kk;
      logic [15:0] op;
      x = 4'($urandom); y = 4'($urandom); n = 4'($urandom);
      kk = 8'($urandom);
      op = {4'($urandom_range(0, 15)), x, y, n};
      case (op[15:12])
         4'h0: case ($urandom_range(0, 3))
            0: op = 16'h00E0;
            1, 2: op = 16'h00EE;
            default: ;
         endcase
         4'h3, 4'h4: if ($urandom_range(0, 1)) op[7:0] = vreg[x];
         4'h8: if ($urandom_range(0, 9) != 0) begin
            n = 4'($urandom_range(0, 8));
            op[3:0] = (n == 4'd8) ? 4'hE : n;
         end
         4'hE: case ($urandom_range(0, 4))
            0, 1: op[7:0] = 8'h9E;
            2, 3: op[7:0] = 8'hA1;
            default: ;
         endcase
         4'hF: case ($urandom_range(0, 10))
            0: op[7:0] = 8'h07;
            1: op[7:0] = 8'h0A;
            2: op[7:0] = 8'h15;
            3: op[7:0] = 8'h18;
            4: op[7:0] = 8'h1E;
            5: op[7:0] = 8'h29;
            6: op[7:0] = 8'h33;
            7: op[7:0] = 8'h55;
            8: op[7:0] = 8'h65;
            default: op[7:0] = kk;
         endcase
         default: ;
      endcase
      return op;
   endfunction

   task automatic random_traffic(int count);
      int roll;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 66) run_program_step(pick_opcode());
         else if (roll < 74) run_in_place();
         else if (roll < 80) send_cmd(CMD_TICK, 12'($urandom), 8'($urandom));
         else if (roll < 85)
            send_cmd(CMD_KEY, 12'($urandom),
                     $urandom_range(0, 2) == 0 ? 8'd0 :
                     ($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(1, 15))));
         else if (roll < 91)
            send_cmd(CMD_RDMEM, $urandom_range(0, 1) ? 12'($urandom) : idx_q, 8'($urandom));
         else if (roll < 96)
            send_cmd(CMD_RDFB, $urandom_range(0, 4) ? 12'($urandom_range(0, 255))
                                                   : 12'($urandom), 8'($urandom));
         else if (roll < 98) send_cmd(CMD_WRMEM, 12'($urandom), 8'($urandom));
         else send_cmd($urandom_range(0, 1) ? CMD_NOP6 : CMD_NOP7, 12'($urandom),
                       8'($urandom));
      end
   endtask

   // result check
   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tdata[1:0]);
         got.pc     = rsp_tdata[13:2];
         got.opword = rsp_tdata[29:14];
         got.rd     = rsp_tdata[37:30];
         got.vf     = rsp_tdata[45:38];
         got.snd    = rsp_tdata[46];
         checked++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %h", rsp_tdata);
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status || got.pc !== want.pc ||
                got.opword !== want.opword || got.rd !== want.rd ||
                got.vf !== want.vf || got.snd !== want.snd) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result %0d: exp st=%0d pc=%h op=%h rd=%h vf=%h snd=%b,",
                            " got st=%0d pc=%h op=%h rd=%h vf=%h snd=%b"},
                           checked, want.status, want.pc, want.opword, want.rd, want.vf,
                           want.snd, got.status, got.pc, got.opword, got.rd, got.vf,
                           got.snd);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if ($urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(1, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[chip8_instruction_executor] ERROR");
         $finish;
      end
   end

   initial begin
      stim_row_type rows [$];
      outcome_type  at_reset;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      quiet = 1'b0;
      stall_left = 0;
      cycles = 0;
      mismatches = 0;
      checked = 0;
      executed = 0;
      draws = 0;

      foreach (mem_img[i]) mem_img[i] = (i < 80) ? GLYPHS[i] : 8'd0;
      foreach (fb_img[i]) fb_img[i] = 8'd0;
      foreach (vreg[i]) vreg[i] = 8'd0;
      foreach (ret_valid[i]) ret_valid[i] = 1'b0;
      pc_q = 12'h200; idx_q = '0; sp_q = '0;
      delay_q = '0; sound_q = '0; key_q = '0;
      lfsr_q = 16'd44257;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      at_reset = '{status: ST_OK, pc: 12'h200, opword: 16'h0000, rd: 8'hF0, vf: 8'h00,
                   snd: 1'b0};
      rows.push_back('{ROW_CMD, CMD_RDMEM, 12'h000, 16'h00, 1'b1, at_reset});
      at_reset.rd = 8'h80;
      rows.push_back('{ROW_CMD, CMD_RDMEM, 12'h04F, 16'h00, 1'b1, at_reset});
      at_reset.rd = 8'h00;
      rows.push_back('{ROW_CMD, CMD_RDMEM, 12'hFFF, 16'hFF, 1'b1, at_reset});
      rows.push_back('{ROW_CMD, CMD_RDFB,  12'h0FF, 16'h00, 1'b1, at_reset});
      rows.push_back('{ROW_CMD, CMD_RDFB,  12'hFFF, 16'hFF, 1'b1, at_reset});
      rows.push_back('{ROW_CMD, CMD_NOP6,  12'hFFF, 16'hFF, 1'b1, at_reset});
      rows.push_back('{ROW_CMD, CMD_NOP7,  12'h000, 16'h00, 1'b1, at_reset});
      rows.push_back('{ROW_CMD, CMD_TICK,  12'h000, 16'h00, 1'b1, at_reset});
      begin
         logic [15:0] prog [$];
         prog = '{16'h00E0, 16'h0123, 16'h60FF, 16'h6101, 16'h8014, 16'h8015, 16'h8017,
                  16'h8016, 16'h801E, 16'h8010, 16'h8011, 16'h8012, 16'h8013, 16'h8018,
                  16'h6FFF, 16'h8F14, 16'h6FFF, 16'h8F15, 16'h30FF, 16'h40FF, 16'h5010,
                  16'h501F, 16'h901A, 16'h7080, 16'hA000, 16'hD015, 16'hD015, 16'hD010,
                  16'hD3F5, 16'h2FFE, 16'h00EE, 16'hC0FF, 16'hE09E, 16'hE0A1, 16'hE0FF,
                  16'hF007, 16'hF00A, 16'h60FF, 16'hF015, 16'hF018, 16'hF01E, 16'hF029,
                  16'hAFFF, 16'hF033, 16'hFF55, 16'hA300, 16'hFF65, 16'hF0FF, 16'h60FF,
                  16'hB801, 16'h1200};
         foreach (prog[i]) rows.push_back('{ROW_OPCODE, CMD_EXEC, 12'h0, prog[i], 1'b0,
                                            at_reset});
      end
      rows.push_back('{ROW_CMD, CMD_KEY,  12'h000, 16'h05, 1'b0, at_reset});
      rows.push_back('{ROW_OPCODE, CMD_EXEC, 12'h0, 16'h6505, 1'b0, at_reset});
      rows.push_back('{ROW_OPCODE, CMD_EXEC, 12'h0, 16'hE59E, 1'b0, at_reset});
      rows.push_back('{ROW_OPCODE, CMD_EXEC, 12'h0, 16'hE5A1, 1'b0, at_reset});
      rows.push_back('{ROW_OPCODE, CMD_EXEC, 12'h0, 16'hFA0A, 1'b0, at_reset});
      rows.push_back('{ROW_CMD, CMD_TICK, 12'h000, 16'h00, 1'b0, at_reset});
      rows.push_back('{ROW_CMD, CMD_WRMEM, 12'hFFF, 16'hFF, 1'b0, at_reset});
      rows.push_back('{ROW_CMD, CMD_RDMEM, 12'hFFF, 16'h00, 1'b0, at_reset});

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_OPCODE) run_program_step(rows[i].value);
         else send_cmd(rows[i].cmd, rows[i].addr, rows[i].value[7:0], rows[i].hand,
                       rows[i].want);
      end

      // a zero seed freezes the generator
      load_seed(16'h0000);
      run_program_step(16'hC7FF);
      run_program_step(16'hC7FF);

      load_seed(16'h0001);
      random_traffic(130);
      load_seed(16'hFFFF);
      random_traffic(130);
      load_seed(16'($urandom_range(1, 65535)));
      random_traffic(130);
      load_seed(16'($urandom_range(1, 65535)));
      quiet = 1'b1;
      random_traffic(130);

      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d results, %0d instructions executed, %0d of them draws",
               checked, executed, draws);
      $display("seeds 0, 1, 0xFFFF and random; %0d mismatches", mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("[chip8_instruction_executor] OK");
      end else begin
         $display("[chip8_instruction_executor] ERROR");
      end
      $finish;
   end

endmodule
